>>> hdl/light_blink_sequence_player_macros.svh
// assertion macros shared by the blink sequence player files
`ifndef LIGHT_BLINK_SEQUENCE_PLAYER_MACROS_SVH
`define LIGHT_BLINK_SEQUENCE_PLAYER_MACROS_SVH

`ifndef SYNTHESIS
// plain property, checked outside reset
`define LBSP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// overlapping implication, checked outside reset
`define LBSP_ASSERT_IMPL(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);
// next-cycle implication, checked outside reset
`define LBSP_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define LBSP_ASSERT(lbl, clk, rstn, prop, msg)
`define LBSP_ASSERT_IMPL(lbl, clk, rstn, pre, post, msg)
`define LBSP_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif

`endif

>>> hdl/lbsp_pkg.sv
// types, codes and constants of the blink sequence player
`default_nettype none

package lbsp_pkg;

  localparam int MAX_STEPS_DEF  = 16;
  localparam int TIMER_BITS_DEF = 16;

  localparam logic [7:0] FULL_LEVEL = 8'hFF;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 8;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_DONE   = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEPS_IN_USE = 3'd0,
    CFG_LOOP         = 3'd1,
    CFG_RESTORE      = 3'd2,
    CFG_BASE_RED     = 3'd3,
    CFG_BASE_GREEN   = 3'd4,
    CFG_BASE_BLUE    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam rgb_t BASE_RESET = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF};

  typedef struct packed {
    logic [4:0] steps_in_use;
    logic       loop_enable;
    logic       restore_enable;
    rgb_t       base;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  step_slot;
    logic [7:0]  flash_count;
    logic [15:0] flash_ticks;
    logic [15:0] pause_ticks;
    logic [7:0]  flash_level;
    logic [7:0]  flash_red;
    logic [7:0]  flash_green;
    logic [7:0]  flash_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] level;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       playing;
    logic [3:0] current_step;
    logic [1:0] status;
  } out_item_t;

  // one table entry: timing and look
  typedef struct packed {
    logic [7:0]  count;
    logic [15:0] flash_ticks;
    logic [15:0] pause_ticks;
    logic [7:0]  level;
    rgb_t        color;
  } step_t;

  typedef struct packed {
    logic       en;
    logic [3:0] slot;
    step_t      data;
  } step_wr_t;

endpackage

`default_nettype wire

>>> hdl/lbsp_if.sv
// request channel interfaces of the blink sequence player
`default_nettype none

interface lbsp_in_if import lbsp_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lbsp_out_if import lbsp_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/lbsp_step_table.sv
// step table: register file with per-slot loaded bits
`default_nettype none

module lbsp_step_table import lbsp_pkg::*; #(
  parameter int  MAX_STEPS = MAX_STEPS_DEF,
  localparam int IDX_W     = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire step_wr_t             wr_i,
  input  wire logic [IDX_W-1:0]     rd_idx_i,
  input  wire logic [4:0]           steps_in_use_i,
  output step_t                     rd_o,
  output logic                      all_loaded_o
);

  localparam int SW    = (IDX_W + 1 > 5) ? IDX_W + 1 : 5;

  step_t                entries_q [MAX_STEPS];
  logic [MAX_STEPS-1:0] loaded_q, loaded_d;
  logic [IDX_W+3:0]     slot_ext;
  logic [IDX_W-1:0]     wr_idx;
  logic [MAX_STEPS-1:0] slot_ok;

  assign slot_ext = {{IDX_W{1'b0}}, wr_i.slot};
  assign wr_idx   = slot_ext[IDX_W-1:0];

  always_comb begin
    loaded_d = loaded_q;
    if (wr_i.en) begin
      loaded_d[wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
    end else begin
      loaded_q <= loaded_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      entries_q[wr_idx] <= wr_i.data;
    end
  end

  // an unloaded slot reads as all zero
  assign rd_o = loaded_q[rd_idx_i] ? entries_q[rd_idx_i] : '0;

  always_comb begin
    for (int i = 0; i < MAX_STEPS; i++) begin
      slot_ok[i] = loaded_q[i] || (SW'(i) >= SW'(steps_in_use_i));
    end
  end

  assign all_loaded_o = &slot_ok;

endmodule

`default_nettype wire

>>> hdl/lbsp_player.sv
// sequence player: phase state, timers and output colour
`default_nettype none
`include "light_blink_sequence_player_macros.svh"

module lbsp_player import lbsp_pkg::*; #(
  parameter int  MAX_STEPS  = MAX_STEPS_DEF,
  parameter int  TIMER_BITS = TIMER_BITS_DEF,
  localparam int IDX_W      = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire in_item_t         item_i,
  input  wire cfg_t             cfg_i,
  input  wire step_t            rd_i,
  input  wire logic             all_loaded_i,
  output logic [IDX_W-1:0]      rd_idx_o,
  output step_wr_t              wr_o,
  output out_item_t             res_o
);

  localparam int SW    = (IDX_W + 1 > 5) ? IDX_W + 1 : 5;
  localparam int CW    = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  logic                  running_q, running_d;
  logic                  in_flash_q, in_flash_d;
  logic [IDX_W-1:0]      step_idx_q, step_idx_d;
  logic [7:0]            flashes_q, flashes_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d;
  logic [7:0]            out_level_q, out_level_d;
  rgb_t                  out_color_q, out_color_d;
  logic [7:0]            saved_level_q, saved_level_d;
  rgb_t                  saved_color_q, saved_color_d;

  logic [TIMER_BITS-1:0] timer_inc;
  logic                  flash_hit, pause_hit;
  logic [IDX_W:0]        next_idx;
  logic                  last_step;
  logic                  slot_ok, write_ok, start_ok;
  logic [IDX_W+3:0]      idx_ext;
  status_e               status;
  op_e                   op;

  assign op = op_e'(item_i.operation);

  // the timer saturates, so a length beyond its range ends at the top value
  assign timer_inc = (&timer_q) ? timer_q : timer_q + TIMER_BITS'(1);
  assign flash_hit = (CW'(timer_inc) >= CW'(rd_i.flash_ticks)) || (&timer_inc);
  assign pause_hit = (CW'(timer_inc) >= CW'(rd_i.pause_ticks)) || (&timer_inc);

  assign next_idx  = {1'b0, step_idx_q} + {{IDX_W{1'b0}}, 1'b1};
  assign last_step = (SW'(next_idx) >= SW'(cfg_i.steps_in_use)) ||
                     (SW'(next_idx) >= SW'(MAX_STEPS));

  assign slot_ok  = SW'(item_i.step_slot) < SW'(MAX_STEPS);
  assign write_ok = slot_ok && (item_i.flash_count != 8'd0) && (item_i.flash_ticks != 16'd0);
  assign start_ok = (cfg_i.steps_in_use != 5'd0) &&
                    !(SW'(cfg_i.steps_in_use) > SW'(MAX_STEPS)) && all_loaded_i;

  // start shows step 0 at once
  assign rd_idx_o = (op == OP_START) ? '0 : step_idx_q;

  always_comb begin
    wr_o.en               = 1'b0;
    wr_o.slot             = item_i.step_slot;
    wr_o.data.count       = item_i.flash_count;
    wr_o.data.flash_ticks = item_i.flash_ticks;
    wr_o.data.pause_ticks = item_i.pause_ticks;
    wr_o.data.level       = item_i.flash_level;
    wr_o.data.color.red   = item_i.flash_red;
    wr_o.data.color.green = item_i.flash_green;
    wr_o.data.color.blue  = item_i.flash_blue;

    running_d     = running_q;
    in_flash_d    = in_flash_q;
    step_idx_d    = step_idx_q;
    flashes_d     = flashes_q;
    timer_d       = timer_q;
    out_level_d   = out_level_q;
    out_color_d   = out_color_q;
    saved_level_d = saved_level_q;
    saved_color_d = saved_color_q;
    status        = ST_OK;

    if (fire_i) begin
      case (op)
        OP_TICK: begin
          if (running_q) begin
            timer_d = timer_inc;
            if (in_flash_q) begin
              out_level_d = rd_i.level;
              out_color_d = rd_i.color;
              if (flash_hit) begin
                in_flash_d = 1'b0;
                timer_d    = '0;
                if (flashes_q != 8'hFF) begin
                  flashes_d = flashes_q + 8'd1;
                end
              end
            end else begin
              out_level_d = FULL_LEVEL;
              out_color_d = cfg_i.base;
              if (pause_hit) begin
                in_flash_d = 1'b1;
                timer_d    = '0;
                if (flashes_q >= rd_i.count) begin
                  flashes_d = '0;
                  if (!last_step) begin
                    step_idx_d = next_idx[IDX_W-1:0];
                  end else if (cfg_i.loop_enable) begin
                    step_idx_d = '0;
                  end else begin
                    running_d   = 1'b0;
                    in_flash_d  = 1'b0;
                    step_idx_d  = '0;
                    timer_d     = '0;
                    out_level_d = cfg_i.restore_enable ? saved_level_q : FULL_LEVEL;
                    out_color_d = cfg_i.restore_enable ? saved_color_q : cfg_i.base;
                    status      = ST_DONE;
                  end
                end
              end
            end
          end
        end
        OP_WRITE: begin
          if (write_ok) begin
            wr_o.en = 1'b1;
          end else begin
            status = ST_REJECT;
          end
        end
        OP_START: begin
          if (start_ok) begin
            saved_level_d = out_level_q;
            saved_color_d = out_color_q;
            running_d     = 1'b1;
            in_flash_d    = 1'b1;
            step_idx_d    = '0;
            flashes_d     = '0;
            timer_d       = '0;
            out_level_d   = rd_i.level;
            out_color_d   = rd_i.color;
          end else begin
            status = ST_REJECT;
          end
        end
        OP_STOP: begin
          if (running_q) begin
            running_d   = 1'b0;
            in_flash_d  = 1'b0;
            step_idx_d  = '0;
            flashes_d   = '0;
            timer_d     = '0;
            out_level_d = cfg_i.restore_enable ? saved_level_q : FULL_LEVEL;
            out_color_d = cfg_i.restore_enable ? saved_color_q : cfg_i.base;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign idx_ext = {4'b0000, step_idx_d};

  always_comb begin
    res_o.level        = out_level_d;
    res_o.red          = out_color_d.red;
    res_o.green        = out_color_d.green;
    res_o.blue         = out_color_d.blue;
    res_o.playing      = running_d;
    res_o.current_step = running_d ? idx_ext[3:0] : 4'd0;
    res_o.status       = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q     <= 1'b0;
      in_flash_q    <= 1'b0;
      step_idx_q    <= '0;
      flashes_q     <= '0;
      timer_q       <= '0;
      out_level_q   <= FULL_LEVEL;
      out_color_q   <= BASE_RESET;
      saved_level_q <= FULL_LEVEL;
      saved_color_q <= BASE_RESET;
    end else begin
      running_q     <= running_d;
      in_flash_q    <= in_flash_d;
      step_idx_q    <= step_idx_d;
      flashes_q     <= flashes_d;
      timer_q       <= timer_d;
      out_level_q   <= out_level_d;
      out_color_q   <= out_color_d;
      saved_level_q <= saved_level_d;
      saved_color_q <= saved_color_d;
    end
  end

  `LBSP_ASSERT_IMPL(a_idle_clear, clk_i, rst_ni, !running_q, !in_flash_q && step_idx_q == '0 && flashes_q == 8'd0 && timer_q == '0, "idle player holds leftover sequence state")
  `LBSP_ASSERT_NEXT(a_start_runs, clk_i, rst_ni, fire_i && op == OP_START && start_ok, running_q && in_flash_q && step_idx_q == '0, "accepted start did not enter step 0 flash")

endmodule

`default_nettype wire

>>> hdl/light_blink_sequence_player.sv
// top level of the blink sequence player: channels, configuration and pipeline registers
//
// usage
// - requests arrive on in_i (valid/ready); a request is taken at a clock edge with
//   valid and ready both high. each request gives exactly one result on out_o
// - operations: tick advances the running sequence by one tick, write step loads a
//   table slot, start plays from step 0, stop ends the sequence
// - configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i); the user
//   writes it only while no request is in flight, which the block does not enforce;
//   unknown indexes are ignored
// - a request is held in the input register, processed in a single pass by the
//   player and lands in the result register when it advances
// - throughput: one request per cycle while the receiver does not stall; the player
//   updates phase timer, flash counter and one step table read in a single pass
// - when the receiver stalls, the result register holds and the input register
//   takes one more request; in_i.ready drops only with both registers full
// - reset clears the step table loaded bits, stops the player and shows full level
//   with the reset base colour; configuration returns to its reset values
`default_nettype none
`include "light_blink_sequence_player_macros.svh"

module light_blink_sequence_player import lbsp_pkg::*; #(
  parameter int MAX_STEPS  = MAX_STEPS_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  lbsp_in_if.sink                   in_i,
  lbsp_out_if.source                out_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DW-1:0]    cfg_data_i
);

  localparam int IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  // configuration registers
  cfg_t cfg_q, cfg_d;

  // pipeline registers
  logic      in_vld_q, in_vld_d;
  in_item_t  in_q, in_d;
  logic      out_vld_q, out_vld_d;
  out_item_t out_q, out_d;

  logic             in_ready;
  logic             advance;
  step_t            rd;
  step_wr_t         wr;
  logic [IDX_W-1:0] rd_idx;
  logic             all_loaded;
  out_item_t        res;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_STEPS_IN_USE: cfg_d.steps_in_use   = cfg_data_i[4:0];
        CFG_LOOP:         cfg_d.loop_enable    = cfg_data_i[0];
        CFG_RESTORE:      cfg_d.restore_enable = cfg_data_i[0];
        CFG_BASE_RED:     cfg_d.base.red       = cfg_data_i;
        CFG_BASE_GREEN:   cfg_d.base.green     = cfg_data_i;
        CFG_BASE_BLUE:    cfg_d.base.blue      = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.steps_in_use   <= 5'd1;
      cfg_q.loop_enable    <= 1'b0;
      cfg_q.restore_enable <= 1'b1;
      cfg_q.base           <= BASE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // the held request moves on when the result register is empty or being drained
  assign advance  = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_ready = !in_vld_q || advance;

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  always_comb begin
    in_vld_d = in_vld_q;
    in_d     = in_q;
    if (in_i.valid && in_ready) begin
      in_vld_d = 1'b1;
      in_d     = in_i.data;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (advance) begin
      out_vld_d = 1'b1;
      out_d     = res;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers need no reset
  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  lbsp_step_table #(
    .MAX_STEPS (MAX_STEPS)
  ) u_table (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_i           (wr),
    .rd_idx_i       (rd_idx),
    .steps_in_use_i (cfg_q.steps_in_use),
    .rd_o           (rd),
    .all_loaded_o   (all_loaded)
  );

  lbsp_player #(
    .MAX_STEPS  (MAX_STEPS),
    .TIMER_BITS (TIMER_BITS)
  ) u_player (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (advance),
    .item_i       (in_q),
    .cfg_i        (cfg_q),
    .rd_i         (rd),
    .all_loaded_i (all_loaded),
    .rd_idx_o     (rd_idx),
    .wr_o         (wr),
    .res_o        (res)
  );

  // a stalled result keeps the next request parked in the input register
  `LBSP_ASSERT_NEXT(a_stall_holds_input, clk_i, rst_ni, in_vld_q && out_vld_q && !out_o.ready, in_vld_q, "input request dropped while result stalled")
  // a finished sequence is never reported as still playing
  `LBSP_ASSERT_IMPL(a_done_stopped, clk_i, rst_ni, out_vld_q && out_q.status == ST_DONE, !out_q.playing, "finished sequence still marked playing")
  // idle results always report step 0
  `LBSP_ASSERT_IMPL(a_idle_step_zero, clk_i, rst_ni, out_vld_q && !out_q.playing, out_q.current_step == 4'd0, "idle result with nonzero step")

endmodule

`default_nettype wire
